[src/conv3_pkg.sv]
// conv3_pkg: shared types and constants of the 3x3 convolution block
// no dependencies
package conv3_pkg;

  localparam int ROW_W      = 13;  // row counters reach height+1
  localparam int PIX_W      = 32;
  localparam int COEF_W     = 12;
  localparam int CREG_W     = 36;
  localparam int DIM_W      = 12;
  localparam int FIFO_DEPTH = 8;

  localparam logic [2:0] REG_COEF_TOP = 3'd0;
  localparam logic [2:0] REG_COEF_MID = 3'd1;
  localparam logic [2:0] REG_COEF_BOT = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_in;
  } src_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_frame;
  } dst_t;

  // per-item control passed from the counter stage to the window stage
  typedef struct packed {
    logic             emit;
    logic             x_zero;
    logic             clamp_l;
    logic             clamp_r;
    logic             clamp_t;
    logic             clamp_b;
    logic             eof;
    logic [PIX_W-1:0] value;
  } ctl_t;

  // selected taps: [column left/centre/right][row top/mid/bottom], rgb only
  typedef struct packed {
    logic                 eof;
    logic [7:0]           alpha;
    logic [2:0][2:0][23:0] rgb;
  } tap_t;

endpackage

[src/conv3_lstore.sv]
// conv3_lstore: both line stores in one synchronous memory, registered read
// depends on nothing; forwards a write that lands on the address just read
module conv3_lstore #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [63:0]              wr_data,
  output logic [63:0]              rd_data
);

  logic [63:0] mem [DEPTH];
  logic [63:0] q;
  logic [63:0] fwd_data;
  logic        fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
    fwd_data <= wr_data;
  end

  // same-address write and read in one cycle: memory returns old word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= rd_en && wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : q;

endmodule

[src/conv3_window.sv]
// conv3_window: 3x3 pixel window, line store write-back and tap selection
// depends on conv3_pkg
module conv3_window
  import conv3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s1_valid,
  input  ctl_t        ctl,
  input  logic [63:0] rd_data,
  output logic [63:0] wr_data,
  output logic        tap_valid,
  output tap_t        taps
);

  logic [2:0][2:0][PIX_W-1:0] win;   // [column][row], column 2 newest
  logic [2:0][2:0][PIX_W-1:0] post;
  logic [2:0][2:0][PIX_W-1:0] src;
  logic [2:0][PIX_W-1:0]      new_col;
  tap_t                       sel;

  assign new_col[0] = rd_data[63:32];
  assign new_col[1] = rd_data[31:0];
  assign new_col[2] = ctl.value;
  assign wr_data    = {rd_data[31:0], ctl.value};

  assign post[0] = win[1];
  assign post[1] = win[2];
  assign post[2] = new_col;

  always_comb begin
    logic [1:0] cl, cc, cr, rt, rb;
    if (ctl.x_zero) begin
      // last column of the previous row, before the shift
      cc = 2'd2;
      cl = ctl.clamp_l ? 2'd2 : 2'd1;
      cr = 2'd2;
    end else begin
      cc = 2'd1;
      cl = ctl.clamp_l ? 2'd1 : 2'd0;
      cr = ctl.clamp_r ? 2'd1 : 2'd2;
    end
    rt = ctl.clamp_t ? 2'd1 : 2'd0;
    rb = ctl.clamp_b ? 2'd1 : 2'd2;
    src = ctl.x_zero ? win : post;
    sel.eof       = ctl.eof;
    sel.alpha     = src[cc][1][31:24];
    sel.rgb[0][0] = src[cl][rt][23:0];
    sel.rgb[0][1] = src[cl][1][23:0];
    sel.rgb[0][2] = src[cl][rb][23:0];
    sel.rgb[1][0] = src[cc][rt][23:0];
    sel.rgb[1][1] = src[cc][1][23:0];
    sel.rgb[1][2] = src[cc][rb][23:0];
    sel.rgb[2][0] = src[cr][rt][23:0];
    sel.rgb[2][1] = src[cr][1][23:0];
    sel.rgb[2][2] = src[cr][rb][23:0];
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win  <= post;
      taps <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
    end else begin
      tap_valid <= s1_valid && ctl.emit;
    end
  end

endmodule

[src/conv3_mac.sv]
// conv3_mac: weighted sums of the nine taps per channel, floor and clamp
// depends on conv3_pkg; two register stages
module conv3_mac
  import conv3_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tap_valid,
  input  tap_t                   taps,
  input  logic [2:0][CREG_W-1:0] coef,   // [row]
  output logic [1:0]             busy,
  output logic                   res_valid,
  output dst_t                   res
);

  logic signed [20:0] prod [3][3][3];   // [channel][column][row]
  logic signed [22:0] part [3][3];      // [channel][column]
  logic               v_prod, v_part;
  logic [7:0]         alpha_p, alpha_s;
  logic               eof_p, eof_s;
  logic [2:0][7:0]    chan;

  always_ff @(posedge clk) begin
    logic signed [COEF_W-1:0] wt;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          // column slots: left bits 23..12, centre 11..0, right 35..24
          unique case (k)
            0:       wt = coef[r][23:12];
            1:       wt = coef[r][11:0];
            default: wt = coef[r][35:24];
          endcase
          prod[c][k][r] <= $signed({1'b0, taps.rgb[k][r][8*c +: 8]}) * wt;
        end
      end
    end
    alpha_p <= taps.alpha;
    eof_p   <= taps.eof;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        part[c][k] <= 23'(prod[c][k][0]) + 23'(prod[c][k][1]) + 23'(prod[c][k][2]);
      end
    end
    alpha_s <= alpha_p;
    eof_s   <= eof_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_prod <= 1'b0;
      v_part <= 1'b0;
    end else begin
      v_prod <= tap_valid;
      v_part <= v_prod;
    end
  end

  always_comb begin
    logic signed [24:0] sum;
    logic [24:0]        sh;
    for (int c = 0; c < 3; c++) begin
      sum = 25'(part[c][0]) + 25'(part[c][1]) + 25'(part[c][2]);
      sh  = 25'(sum) >> FRAC_BITS;
      if (sum < 0) begin
        chan[c] = 8'd0;
      end else if (sh > 25'd255) begin
        chan[c] = 8'hFF;
      end else begin
        chan[c] = sh[7:0];
      end
    end
  end

  assign res.pixel_out    = {alpha_s, chan[2], chan[1], chan[0]};
  assign res.end_of_frame = eof_s;
  assign res_valid        = v_part;
  assign busy             = {v_part, v_prod};

endmodule

[src/conv3_ofifo.sv]
// conv3_ofifo: result queue between the arithmetic pipeline and the output
// depends on conv3_pkg
module conv3_ofifo
  import conv3_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  dst_t                       wr_data,
  output logic                       rd_valid,
  input  logic                       rd_ready,
  output dst_t                       rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);

  dst_t          mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic          rd_en;

  assign rd_valid = (count != '0);
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + ($clog2(DEPTH+1))'(wr_en) - ($clog2(DEPTH+1))'(rd_en);
    end
  end

endmodule

[src/image_convolution_3x3_top.sv]
// image_convolution_3x3_top: 3x3 clamp-to-edge convolution of an argb stream
// a result passes the stage 1, window, product and sum registers and the queue before it is offered
// throughput: one request per cycle while the queue has room, set by one read and one
//   write per cycle on the shared line store memory; results queue in an eight-entry buffer
// reset: counters cleared, weights identity, 640x480, pipeline and queue empty;
//   line stores are not cleared (never-written entries are masked by clamping)
module image_convolution_3x3_top
  import conv3_pkg::*;
#(
  parameter int MAX_WIDTH      = 2048,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  src_t              src_data,
  output logic              dst_valid,
  input  logic              dst_ready,
  output dst_t              dst_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [CREG_W-1:0] cfg_data
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);

  // configuration registers
  logic [2:0][CREG_W-1:0] coef;
  logic [DIM_W-1:0]       frame_width, frame_height;
  logic                   cfg_we, geom_we;

  // frame position counters
  logic [AW-1:0]    in_column, out_column;
  logic [ROW_W-1:0] in_row, out_row;

  // effective geometry
  logic [WW-1:0]    w;
  logic [ROW_W-1:0] h;

  // request decode
  logic          drain, emit, drop, accept, go, eof;
  logic [AW-1:0] xc;
  logic [WW:0]   x_inc;

  // window stage
  logic          s1_valid;
  ctl_t          s1_ctl;
  logic [AW-1:0] s1_addr;
  logic [63:0]   rd_data, wr_data;
  logic          tap_valid;
  tap_t          taps;

  // arithmetic and queue
  logic [1:0]     mac_busy;
  logic           res_valid;
  dst_t           res;
  logic [FCW-1:0] fifo_count;
  logic [FCW:0]   load;

  // config port never stalls
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign geom_we   = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0]      <= '0;
      coef[1]      <= CREG_W'(256);
      coef[2]      <= '0;
      frame_width  <= DIM_W'(640);
      frame_height <= DIM_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_TOP: coef[0]      <= cfg_data;
        REG_COEF_MID: coef[1]      <= cfg_data;
        REG_COEF_BOT: coef[2]      <= cfg_data;
        REG_WIDTH:    frame_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:   frame_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width or height counts as one, wider than the line store counts as full depth
  always_comb begin
    if (frame_width == '0) begin
      w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width);
    end
    h = (frame_height == '0) ? ROW_W'(1) : ROW_W'(frame_height);
  end

  // drains count as virtual rows h and h+1; early drains and late pixels drop
  assign drain  = (src_data.kind == KIND_DRAIN);
  assign emit   = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_column != '0));
  assign drop   = drain ? (in_row < h) : (in_row >= h);
  assign accept = src_valid && src_ready;
  assign go     = accept && !drop;
  assign xc     = (WW'(in_column) >= w) ? '0 : in_column;
  assign x_inc  = (WW + 1)'(xc) + 1'b1;
  assign eof    = (out_row >= h - 1'b1) && (WW'(out_column) >= w - 1'b1);

  always_ff @(posedge clk) begin
    if (rst || geom_we) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (go) begin
      if (x_inc >= (WW + 1)'(w)) begin
        in_column <= '0;
        in_row    <= in_row + 1'b1;
      end else begin
        in_column <= x_inc[AW-1:0];
      end
      if (emit) begin
        if (eof) begin
          // end of frame: every position returns to the start
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end else if (WW'(out_column) >= w - 1'b1) begin
          out_column <= '0;
          out_row    <= out_row + 1'b1;
        end else begin
          out_column <= out_column + 1'b1;
        end
      end
    end
  end

  // stage 1 control, memory read issued in the same cycle
  always_ff @(posedge clk) begin
    if (go) begin
      s1_addr        <= xc;
      s1_ctl.emit    <= emit;
      s1_ctl.x_zero  <= (xc == '0);
      s1_ctl.clamp_l <= (out_column == '0);
      s1_ctl.clamp_r <= (WW'(out_column) >= w - 1'b1);
      s1_ctl.clamp_t <= (out_row == '0);
      s1_ctl.clamp_b <= (out_row >= h - 1'b1);
      s1_ctl.eof     <= eof;
      s1_ctl.value   <= drain ? '0 : src_data.pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= go;
    end
  end

  // line stores: upper half the row two back, lower half the row one back
  conv3_lstore #(
    .DEPTH (MAX_WIDTH)
  ) u_lstore (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (go),
    .rd_addr (xc),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  conv3_window u_window (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .ctl       (s1_ctl),
    .rd_data   (rd_data),
    .wr_data   (wr_data),
    .tap_valid (tap_valid),
    .taps      (taps)
  );

  conv3_mac #(
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (tap_valid),
    .taps      (taps),
    .coef      (coef),
    .busy      (mac_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  conv3_ofifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_ofifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .rd_valid (dst_valid),
    .rd_ready (dst_ready),
    .rd_data  (dst_data),
    .count    (fifo_count)
  );

  // take a request only if the queue can hold every result still in flight
  assign load = (FCW + 1)'(fifo_count) + (FCW + 1)'(s1_valid) + (FCW + 1)'(tap_valid)
              + (FCW + 1)'(mac_busy[0]) + (FCW + 1)'(mac_busy[1]);
  assign src_ready = (load < (FCW + 1)'(FIFO_DEPTH));

endmodule

[src/conv3_checker.sv]
// conv3_checker: port-level checks of the convolution block
// depends on conv3_pkg; bound to image_convolution_3x3_top below
module conv3_checker
  import conv3_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic src_valid,
  input logic src_ready,
  input logic dst_valid,
  input logic dst_ready,
  input dst_t dst_data,
  input logic cfg_valid,
  input logic cfg_ready
);

  // a held result keeps its value
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
    else $error("result changed while stalled");

  // reset empties the queue and the pipeline
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !dst_valid)
    else $error("result present after reset");

  a_rst_ready: assert property (@(posedge clk) $past(rst) |-> src_ready)
    else $error("request not taken after reset");

  // configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind image_convolution_3x3_top conv3_checker u_conv3_checker (.*);
